### rtl/plid_pkg.sv
// shared constants and types for the plane intersection direction block
package plid_pkg;

    // result component width and wrap width of the wide arithmetic
    localparam int OUT_W = 32;
    localparam int ACC_W = 64;

    // per-item control that travels beside the datapath
    typedef struct packed {
        logic       degen;
        logic [2:0] neg;
    } ctl_t;

endpackage

### rtl/plid_in_if.sv
// input channel: four spanning vectors with valid/ready handshake
interface plid_in_if #(
    parameter int IN_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] a_u_x;
    logic signed [IN_WIDTH-1:0] a_u_y;
    logic signed [IN_WIDTH-1:0] a_u_z;
    logic signed [IN_WIDTH-1:0] a_v_x;
    logic signed [IN_WIDTH-1:0] a_v_y;
    logic signed [IN_WIDTH-1:0] a_v_z;
    logic signed [IN_WIDTH-1:0] b_u_x;
    logic signed [IN_WIDTH-1:0] b_u_y;
    logic signed [IN_WIDTH-1:0] b_u_z;
    logic signed [IN_WIDTH-1:0] b_v_x;
    logic signed [IN_WIDTH-1:0] b_v_y;
    logic signed [IN_WIDTH-1:0] b_v_z;

    modport source (
        output valid, a_u_x, a_u_y, a_u_z, a_v_x, a_v_y, a_v_z,
               b_u_x, b_u_y, b_u_z, b_v_x, b_v_y, b_v_z,
        input  ready
    );
    modport sink (
        input  valid, a_u_x, a_u_y, a_u_z, a_v_x, a_v_y, a_v_z,
               b_u_x, b_u_y, b_u_z, b_v_x, b_v_y, b_v_z,
        output ready
    );
endinterface

### rtl/plid_out_if.sv
// output channel: line direction and degenerate flag with valid/ready handshake
interface plid_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic signed [plid_pkg::OUT_W-1:0]    dir_x;
    logic signed [plid_pkg::OUT_W-1:0]    dir_y;
    logic signed [plid_pkg::OUT_W-1:0]    dir_z;
    logic                                 degenerate;

    modport source (
        output valid, dir_x, dir_y, dir_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, dir_x, dir_y, dir_z, degenerate,
        output ready
    );
endinterface

### rtl/plid_front.sv
// front pipeline: cross product, dot products, ratio numerators and divisor setup
module plid_front #(
    parameter int IN_WIDTH = 16,
    parameter int NW       = 33,
    parameter int PW       = 50,
    parameter int MW       = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0][IN_WIDTH-1:0]     au,
    input  logic [2:0][IN_WIDTH-1:0]     av,
    input  logic [2:0][IN_WIDTH-1:0]     bu,
    input  logic [2:0][IN_WIDTH-1:0]     bv,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][MW-1:0]           num,
    output logic [PW-1:0]                den,
    output plid_pkg::ctl_t               ctl,
    output logic [6*IN_WIDTH-1:0]        carry
);
    localparam int W   = IN_WIDTH;
    localparam int PRW = 2 * IN_WIDTH;
    localparam int CW  = 6 * IN_WIDTH;
    localparam int S   = 6;

    logic                  valid_reg [S];
    logic                  rdy [S+1];

    logic [CW-1:0]         cb_reg [S];
    logic                  au0z_reg [4];

    logic signed [W-1:0]   s_au [3];
    logic signed [W-1:0]   s_av [3];
    logic signed [W-1:0]   bu1 [3];
    logic signed [W-1:0]   bu3 [3];
    logic signed [W-1:0]   bv1 [3];

    logic signed [PRW-1:0] prod_nx [6];
    logic signed [PRW-1:0] prod_reg [6];
    logic signed [NW-1:0]  n_nx [3];
    logic signed [NW-1:0]  n_reg [3];
    logic signed [NW+W-1:0] pbf [3];
    logic signed [NW+W-1:0] qbf [3];
    logic signed [PW-1:0]  pb_reg [3];
    logic signed [PW-1:0]  qb_reg [3];
    logic signed [PW-1:0]  p_nx;
    logic signed [PW-1:0]  q_nx;
    logic signed [PW-1:0]  p_reg;
    logic signed [PW-1:0]  q_reg;
    logic signed [PW+W-1:0] mf [3];
    logic signed [MW-1:0]  m_reg [3];
    logic [PW-1:0]         den4_nx;
    logic [PW-1:0]         den4_reg;
    logic                  pneg_reg;
    logic                  degen_reg;
    logic [2:0][MW-1:0]    num_nx;
    logic [2:0][MW-1:0]    num_reg;
    logic [PW-1:0]         den5_reg;
    plid_pkg::ctl_t        ctl_nx;
    plid_pkg::ctl_t        ctl_reg;

    // ready ripples back through the stages so bubbles collapse
    always_comb
    begin
        rdy[S] = out_ready;
        for (int i = S - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < S; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < S; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_au[k] = au[k];
            s_av[k] = av[k];
            bu1[k]  = cb_reg[1][k*W +: W];
            bv1[k]  = cb_reg[1][(3+k)*W +: W];
            bu3[k]  = cb_reg[3][k*W +: W];
        end
        // cross product terms
        prod_nx[0] = s_au[1] * s_av[2];
        prod_nx[1] = s_au[2] * s_av[1];
        prod_nx[2] = s_au[2] * s_av[0];
        prod_nx[3] = s_au[0] * s_av[2];
        prod_nx[4] = s_au[0] * s_av[1];
        prod_nx[5] = s_au[1] * s_av[0];
        for (int k = 0; k < 3; k++)
        begin
            n_nx[k] = NW'(prod_reg[2*k]) - NW'(prod_reg[2*k+1]);
            pbf[k]  = n_reg[k] * bu1[k];
            qbf[k]  = n_reg[k] * bv1[k];
            mf[k]   = q_reg * bu3[k];
        end
        p_nx    = pb_reg[0] + pb_reg[1] + pb_reg[2];
        q_nx    = qb_reg[0] + qb_reg[1] + qb_reg[2];
        den4_nx = p_reg[PW-1] ? (PW'(0) - p_reg) : p_reg;
        for (int k = 0; k < 3; k++)
        begin
            num_nx[k]     = m_reg[k][MW-1] ? (MW'(0) - m_reg[k]) : m_reg[k];
            ctl_nx.neg[k] = m_reg[k][MW-1] ^ pneg_reg;
        end
        ctl_nx.degen = degen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int k = 0; k < 6; k++)
            begin
                prod_reg[k] <= prod_nx[k];
            end
            cb_reg[0]   <= {bv, bu};
            au0z_reg[0] <= (au[0] == '0);
        end
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= n_nx[k];
            end
            au0z_reg[1] <= au0z_reg[0];
        end
        if (rdy[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pb_reg[k] <= PW'(pbf[k]);
                qb_reg[k] <= PW'(qbf[k]);
            end
            au0z_reg[2] <= au0z_reg[1];
        end
        if (rdy[3])
        begin
            p_reg       <= p_nx;
            q_reg       <= q_nx;
            au0z_reg[3] <= au0z_reg[2];
        end
        if (rdy[4])
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k] <= MW'(mf[k]);
            end
            den4_reg  <= den4_nx;
            pneg_reg  <= p_reg[PW-1];
            degen_reg <= au0z_reg[3] || (p_reg == '0);
        end
        if (rdy[5])
        begin
            num_reg  <= num_nx;
            den5_reg <= den4_reg;
            ctl_reg  <= ctl_nx;
        end
        for (int i = 1; i < S; i++)
        begin
            if (rdy[i])
            begin
                cb_reg[i] <= cb_reg[i-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[S-1];
    assign num       = num_reg;
    assign den       = den5_reg;
    assign ctl       = ctl_reg;
    assign carry     = cb_reg[S-1];

endmodule

### rtl/plid_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module plid_div #(
    parameter int NUM_W   = 64,
    parameter int DEN_W   = 50,
    parameter int CARRY_W = 96
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0][NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]         den,
    input  plid_pkg::ctl_t           ctl,
    input  logic [CARRY_W-1:0]       carry,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0][NUM_W-1:0]    quo,
    output logic [2:0][DEN_W-1:0]    rem,
    output logic [DEN_W-1:0]         den_out,
    output plid_pkg::ctl_t           ctl_out,
    output logic [CARRY_W-1:0]       carry_out
);
    logic                     valid_reg [NUM_W];
    logic                     rdy [NUM_W+1];
    logic [2:0][NUM_W-1:0]    nq_reg [NUM_W];
    logic [2:0][DEN_W-1:0]    rm_reg [NUM_W];
    logic [DEN_W-1:0]         dn_reg [NUM_W];
    plid_pkg::ctl_t           ct_reg [NUM_W];
    logic [CARRY_W-1:0]       cy_reg [NUM_W];

    assign rdy[NUM_W] = out_ready;

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic                  v_in;
        logic [2:0][NUM_W-1:0] nq_in;
        logic [2:0][DEN_W-1:0] rm_in;
        logic [DEN_W-1:0]      dn_in;
        plid_pkg::ctl_t        ct_in;
        logic [CARRY_W-1:0]    cy_in;
        logic [2:0][NUM_W-1:0] nq_nx;
        logic [2:0][DEN_W-1:0] rm_nx;

        if (s == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign nq_in = num;
            assign rm_in = '0;
            assign dn_in = den;
            assign ct_in = ctl;
            assign cy_in = carry;
        end
        else
        begin : g_next
            assign v_in  = valid_reg[s-1];
            assign nq_in = nq_reg[s-1];
            assign rm_in = rm_reg[s-1];
            assign dn_in = dn_reg[s-1];
            assign ct_in = ct_reg[s-1];
            assign cy_in = cy_reg[s-1];
        end

        assign rdy[s] = !valid_reg[s] || rdy[s+1];

        // shift in the next numerator bit, subtract when it fits
        always_comb
        begin
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            for (int k = 0; k < 3; k++)
            begin
                trial     = {rm_in[k], nq_in[k][NUM_W-1]};
                diff      = trial - {1'b0, dn_in};
                ge        = trial >= {1'b0, dn_in};
                rm_nx[k]  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_nx[k]  = {nq_in[k][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                nq_reg[s] <= nq_nx;
                rm_reg[s] <= rm_nx;
                dn_reg[s] <= dn_in;
                ct_reg[s] <= ct_in;
                cy_reg[s] <= cy_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign rem       = rm_reg[NUM_W-1];
    assign den_out   = dn_reg[NUM_W-1];
    assign ctl_out   = ct_reg[NUM_W-1];
    assign carry_out = cy_reg[NUM_W-1];

`ifndef SYNTH
    for (genvar s = 0; s < NUM_W; s++)
    begin : g_chk
        a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg[s] && dn_reg[s] != '0 |->
                rm_reg[s][0] < dn_reg[s] && rm_reg[s][1] < dn_reg[s] &&
                rm_reg[s][2] < dn_reg[s])
            else $error("partial remainder not below divisor");
    end

    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_W-1] && !out_ready |=>
            valid_reg[NUM_W-1] && $stable(nq_reg[NUM_W-1]))
        else $error("last divider stage changed while stalled");
`endif

endmodule

### rtl/plid_back.sv
// back pipeline: round the quotient, apply sign, add offset vector, saturate
module plid_back #(
    parameter int IN_WIDTH = 16,
    parameter int NUM_W    = 64,
    parameter int DEN_W    = 50
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0][NUM_W-1:0]               quo,
    input  logic [2:0][DEN_W-1:0]               rem,
    input  logic [DEN_W-1:0]                    den,
    input  plid_pkg::ctl_t                      ctl,
    input  logic [6*IN_WIDTH-1:0]               carry,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [plid_pkg::OUT_W-1:0]   dir_x,
    output logic signed [plid_pkg::OUT_W-1:0]   dir_y,
    output logic signed [plid_pkg::OUT_W-1:0]   dir_z,
    output logic                                degenerate
);
    localparam int W  = IN_WIDTH;
    localparam int CW = 6 * IN_WIDTH;
    localparam int OW = plid_pkg::OUT_W;
    localparam int AW = plid_pkg::ACC_W;

    logic                  valid_reg [2];
    logic                  rdy [3];
    logic [2:0][NUM_W-1:0] qr_nx;
    logic [2:0][NUM_W-1:0] qr_reg;
    plid_pkg::ctl_t        ctl_reg;
    logic [CW-1:0]         cb_reg;
    logic signed [OW-1:0]  dir_nx [3];
    logic signed [OW-1:0]  dir_reg [3];
    logic                  degen_reg;

    assign rdy[2] = out_ready;
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];

    // round half away from zero on magnitudes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qr_nx[k] = quo[k] + NUM_W'({rem[k], 1'b0} >= {1'b0, den});
        end
    end

    always_comb
    begin
        logic signed [W-1:0]  bu_k;
        logic signed [W-1:0]  bv_k;
        logic signed [AW-1:0] bvx;
        logic [AW-1:0]        qx;
        logic [AW-1:0]        sum;
        for (int k = 0; k < 3; k++)
        begin
            bu_k = cb_reg[k*W +: W];
            bv_k = cb_reg[(3+k)*W +: W];
            bvx  = AW'(bv_k);
            qx   = AW'(qr_reg[k]);
            sum  = ctl_reg.neg[k] ? (bvx + qx) : (bvx - qx);
            if (ctl_reg.degen)
            begin
                dir_nx[k] = OW'(bu_k);
            end
            else if (sum[AW-1:OW-1] == '0 || sum[AW-1:OW-1] == '1)
            begin
                dir_nx[k] = sum[OW-1:0];
            end
            else if (sum[AW-1])
            begin
                dir_nx[k] = {1'b1, {(OW-1){1'b0}}};
            end
            else
            begin
                dir_nx[k] = {1'b0, {(OW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            qr_reg  <= qr_nx;
            ctl_reg <= ctl;
            cb_reg  <= carry;
        end
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir_reg[k] <= dir_nx[k];
            end
            degen_reg <= ctl_reg.degen;
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = valid_reg[1];
    assign dir_x      = dir_reg[0];
    assign dir_y      = dir_reg[1];
    assign dir_z      = dir_reg[2];
    assign degenerate = degen_reg;

`ifndef SYNTH
    a_degen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && degen_reg |->
            (dir_reg[0][OW-1:W-1] == '0 || dir_reg[0][OW-1:W-1] == '1) &&
            (dir_reg[1][OW-1:W-1] == '0 || dir_reg[1][OW-1:W-1] == '1) &&
            (dir_reg[2][OW-1:W-1] == '0 || dir_reg[2][OW-1:W-1] == '1))
        else $error("degenerate result is not a sign-extended input vector");
`endif

endmodule

### rtl/plane_intersection_direction.sv
// throughput: one item per cycle while the output is ready; the restoring divider retires one quotient bit per stage
// the stage count is set by the width of the ratio numerator Q*b_u
// every stage collapses bubbles, so input transfers continue while a result waits
// reset clears only the valid bits; datapath registers are not reset
// no configuration and no state carried between items
module plane_intersection_direction #(
    parameter int IN_WIDTH = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    plid_in_if.sink         in_ch,
    plid_out_if.source      out_ch
);
    // the fixed-point scale cancels in Q/P; it only documents the port format
    localparam int FRAC_W = FRAC_BITS;
    localparam int AW = plid_pkg::ACC_W;

    // exact widths of the intermediates, wrapped to the accumulator width when larger
    localparam int NW = (2*IN_WIDTH + 1 > AW) ? AW : 2*IN_WIDTH + 1;
    localparam int PW = (3*IN_WIDTH + 2 > AW) ? AW : 3*IN_WIDTH + 2;
    localparam int MW = (4*IN_WIDTH + 1 > AW) ? AW : 4*IN_WIDTH + 1;
    localparam int CW = 6 * IN_WIDTH;

    logic [2:0][IN_WIDTH-1:0] au;
    logic [2:0][IN_WIDTH-1:0] av;
    logic [2:0][IN_WIDTH-1:0] bu;
    logic [2:0][IN_WIDTH-1:0] bv;

    // front to divider
    logic                f_valid;
    logic                f_ready;
    logic [2:0][MW-1:0]  f_num;
    logic [PW-1:0]       f_den;
    plid_pkg::ctl_t      f_ctl;
    logic [CW-1:0]       f_carry;

    // divider to back end
    logic                d_valid;
    logic                d_ready;
    logic [2:0][MW-1:0]  d_quo;
    logic [2:0][PW-1:0]  d_rem;
    logic [PW-1:0]       d_den;
    plid_pkg::ctl_t      d_ctl;
    logic [CW-1:0]       d_carry;

    assign au = {in_ch.a_u_z, in_ch.a_u_y, in_ch.a_u_x};
    assign av = {in_ch.a_v_z, in_ch.a_v_y, in_ch.a_v_x};
    assign bu = {in_ch.b_u_z, in_ch.b_u_y, in_ch.b_u_x};
    assign bv = {in_ch.b_v_z, in_ch.b_v_y, in_ch.b_v_x};

    // n = a_u x a_v, P = n.b_u, Q = n.b_v, then |Q*b_u| and |P| for the divider
    plid_front #(
        .IN_WIDTH (IN_WIDTH),
        .NW       (NW),
        .PW       (PW),
        .MW       (MW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .au        (au),
        .av        (av),
        .bu        (bu),
        .bv        (bv),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .num       (f_num),
        .den       (f_den),
        .ctl       (f_ctl),
        .carry     (f_carry)
    );

    // quotient and remainder of all three components in parallel
    plid_div #(
        .NUM_W   (MW),
        .DEN_W   (PW),
        .CARRY_W (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num       (f_num),
        .den       (f_den),
        .ctl       (f_ctl),
        .carry     (f_carry),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .quo       (d_quo),
        .rem       (d_rem),
        .den_out   (d_den),
        .ctl_out   (d_ctl),
        .carry_out (d_carry)
    );

    // rounding, b_v - round(Q*b_u/P) or b_u when degenerate, saturation; the last stage is the output register
    plid_back #(
        .IN_WIDTH (IN_WIDTH),
        .NUM_W    (MW),
        .DEN_W    (PW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .quo        (d_quo),
        .rem        (d_rem),
        .den        (d_den),
        .ctl        (d_ctl),
        .carry      (d_carry),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .dir_x      (out_ch.dir_x),
        .dir_y      (out_ch.dir_y),
        .dir_z      (out_ch.dir_z),
        .degenerate (out_ch.degenerate)
    );

`ifndef SYNTH
    a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid |-> FRAC_W >= 0 && FRAC_W < IN_WIDTH + 9)
        else $error("fraction width outside supported range");
`endif

endmodule

### tb/sv/plid_direction_board.sv
// scoreboard for the plane intersection direction block: predicts and checks line directions
class plid_direction_board;

    typedef struct {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               degenerate;
    } direction_t;

    direction_t pending[$];
    int         mismatches;
    int         checked;
    int         degenerate_seen;

    function new();
        mismatches      = 0;
        checked         = 0;
        degenerate_seen = 0;
    endfunction

    // clamp to the 32-bit signed range
    static function logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // nearest, ties away from zero
    static function longint round_ratio(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (r >= d - r)
            q++;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // note an accepted input: twelve components in order a_u, a_v, b_u, b_v
    function void note_input(logic signed [15:0] c[12]);
        longint     au[3];
        longint     av[3];
        longint     bu[3];
        longint     bv[3];
        longint     nrm[3];
        longint     p;
        longint     q;
        direction_t e;
        for (int k = 0; k < 3; k++)
        begin
            au[k] = c[k];
            av[k] = c[3 + k];
            bu[k] = c[6 + k];
            bv[k] = c[9 + k];
        end
        nrm[0] = au[1] * av[2] - au[2] * av[1];
        nrm[1] = au[2] * av[0] - au[0] * av[2];
        nrm[2] = au[0] * av[1] - au[1] * av[0];
        p = nrm[0] * bu[0] + nrm[1] * bu[1] + nrm[2] * bu[2];
        q = nrm[0] * bv[0] + nrm[1] * bv[1] + nrm[2] * bv[2];
        if (au[0] == 0 || p == 0)
        begin
            e.dir_x      = clamp32(bu[0]);
            e.dir_y      = clamp32(bu[1]);
            e.dir_z      = clamp32(bu[2]);
            e.degenerate = 1'b1;
        end
        else
        begin
            e.dir_x      = clamp32(bv[0] - round_ratio(q * bu[0], p));
            e.dir_y      = clamp32(bv[1] - round_ratio(q * bu[1], p));
            e.dir_z      = clamp32(bv[2] - round_ratio(q * bu[2], p));
            e.degenerate = 1'b0;
        end
        pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
    endtask

    task check_result(logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic dg);
        direction_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result, dir_x", x, 0);
            return;
        end
        e = pending.pop_front();
        if (x !== e.dir_x)
            report("dir_x", x, e.dir_x);
        if (y !== e.dir_y)
            report("dir_y", y, e.dir_y);
        if (z !== e.dir_z)
            report("dir_z", z, e.dir_z);
        if (dg !== e.degenerate)
            report("degenerate", dg, e.degenerate);
        if (e.degenerate)
            degenerate_seen++;
        checked++;
    endtask

endclass

### tb/sv/plane_intersection_direction_test.sv
// top-level testbench for the plane intersection direction block
module plane_intersection_direction_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    localparam int DRAIN_CYCLES = 200;
    // 1044 items, worst stall rates and the pipe depth, taken many times over
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    plid_in_if #(.IN_WIDTH(16)) in_ch ();
    plid_out_if out_ch ();

    plane_intersection_direction #(
        .IN_WIDTH(16),
        .FRAC_BITS(12)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    plid_direction_board board;

    // idle percentages for sender and receiver, changed per phase
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycle_count;
    int     sent;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: a hung pipe ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // result side: check each transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.check_result(out_ch.dir_x, out_ch.dir_y, out_ch.dir_z,
                               out_ch.degenerate);
    end

    // receiver stall pattern, changed only at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // boundary-heavy component: extremes, zero, small values, 0x1000 or fully random
    function automatic logic signed [15:0] pick_component();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(signed'($urandom_range(8)) - 4);
            4: return 16'sh1000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one item: idle first if the phase asks for it, then present the item
    // at the falling edge and hold it until the transfer
    task automatic send_item(logic signed [15:0] c[12]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.a_u_x <= c[0];
        in_ch.a_u_y <= c[1];
        in_ch.a_u_z <= c[2];
        in_ch.a_v_x <= c[3];
        in_ch.a_v_y <= c[4];
        in_ch.a_v_z <= c[5];
        in_ch.b_u_x <= c[6];
        in_ch.b_u_y <= c[7];
        in_ch.b_u_z <= c[8];
        in_ch.b_v_x <= c[9];
        in_ch.b_v_y <= c[10];
        in_ch.b_v_z <= c[11];
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        board.note_input(c);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_vec(logic signed [15:0] c[12]);
        send_item(c);
    endtask

    // wait until every expected direction has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    logic signed [15:0] item[12];

    initial
    begin
        board          = new();
        cycle_count    = 0;
        sent           = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        out_ch.ready   = 1'b0;
        in_ch.a_u_x = '0; in_ch.a_u_y = '0; in_ch.a_u_z = '0;
        in_ch.a_v_x = '0; in_ch.a_v_y = '0; in_ch.a_v_z = '0;
        in_ch.b_u_x = '0; in_ch.b_u_y = '0; in_ch.b_u_z = '0;
        in_ch.b_v_x = '0; in_ch.b_v_y = '0; in_ch.b_v_z = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: generic planes, zero a_u_x pivot, parallel and equal planes
        item = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 16'sh1000, 0, 16'sh1000,
                 0, 16'sh1000, 16'sh1000};
        send_vec(item);
        item = '{0, 16'sh1000, 16'sh0123, 16'sh0321, 0, 16'sh1000,
                 16'sh0200, 16'sh0300, 16'sh0400, 16'sh0500, 16'sh0600, 16'sh0700};
        send_vec(item);
        // b_u inside the first plane: P is zero
        item = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 16'sh0234, -16'sh0111, 0,
                 16'sh0050, 16'sh0060, 16'sh0070};
        send_vec(item);
        // both planes equal
        item = '{16'sh1000, 16'sh0200, 0, 0, 16'sh1000, 16'sh0300,
                 16'sh1000, 16'sh0200, 0, 0, 16'sh1000, 16'sh0300};
        send_vec(item);
        // all at the positive and negative extremes, mixed
        for (int k = 0; k < 12; k++) item[k] = 16'sh7fff;
        send_vec(item);
        for (int k = 0; k < 12; k++) item[k] = 16'sh8000;
        send_vec(item);
        for (int k = 0; k < 12; k++) item[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
        send_vec(item);
        for (int k = 0; k < 12; k++) item[k] = (k % 3) ? 16'sh7fff : 16'sh8000;
        send_vec(item);
        // small P, large Q: large ratio Q*b_u/P
        item = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_vec(item);
        item = '{1, 0, 0, 0, 1, 0, 16'sh8000, 16'sh7fff, 1,
                 16'sh8000, 16'sh8000, 16'sh7fff};
        send_vec(item);
        // exact halves in the ratio: ties away from zero, both signs
        item = '{1, 0, 0, 0, 1, 0, 1, 0, 2, 0, 0, 1};
        send_vec(item);
        item = '{1, 0, 0, 0, 1, 0, -1, 3, 2, 0, 0, -1};
        send_vec(item);
        item = '{1, 0, 0, 0, 1, 0, 1, 5, -2, 3, 0, 1};
        send_vec(item);
        // all zero
        for (int k = 0; k < 12; k++) item[k] = 0;
        send_vec(item);
        // pause until the pipe is empty
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3: begin send_idle_pct = 24; recv_stall_pct = 24; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            begin
                for (int k = 0; k < 12; k++)
                    item[k] = pick_component();
                // now and then make b_u near a combination of a_u and a_v, so it lies nearly in the first plane
                if ($urandom_range(9) == 0)
                begin
                    for (int k = 0; k < 3; k++)
                        item[6 + k] = (item[k] >>> 2) + (item[3 + k] >>> 2);
                end
                send_vec(item);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items, %0d results checked, %0d of them degenerate",
                 sent, board.checked, board.degenerate_seen);
        $display("idling phases: none, sender 64%%, receiver 64%%, both 24%%");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
